[src/gradient_noise_2d_top_defines.svh]
// gradient_noise_2d_top_defines.svh: assertion macros shared by the RTL.
// Expects i_clk and i_rst_n in the scope of the module that uses them.
`ifndef GRADIENT_NOISE_2D_TOP_DEFINES_SVH
`define GRADIENT_NOISE_2D_TOP_DEFINES_SVH

// Property checked at every clock edge outside reset.
`define GN2D_ASSERT(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Condition at one edge implies an expression at the next edge.
`define GN2D_ASSERT_NEXT(name, cond, expr, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

[src/gn2d_pkg.sv]
`timescale 1ns / 1ps
// gn2d_pkg: constants, command codes and the queue item type of the
// 2D gradient noise block. No dependencies.
package gn2d_pkg;

    localparam int TABLE_SIZE      = 256;
    localparam int IDX_W           = $clog2(TABLE_SIZE);
    localparam int PERM_W          = 8;
    localparam int GRAD_W          = 16;
    localparam int COORD_W         = 32;
    localparam int NOISE_W         = 16;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int QUEUE_DEPTH_DEF = 4;

    // quintic fade, Q0.16 weight
    localparam int FADE_T_W = 16;
    localparam int FADE_W   = 20;
    localparam logic [FADE_W-1:0] FADE_C15 = 20'd983040;
    localparam logic [FADE_W-1:0] FADE_C10 = 20'd655360;

    typedef enum logic [1:0] {
        CMD_EVAL  = 2'd0,
        CMD_WPERM = 2'd1,
        CMD_WGRAD = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd                     kind;
        logic [IDX_W-1:0]         tbl_index;
        logic [PERM_W-1:0]        perm_value;
        logic signed [GRAD_W-1:0] grad_x;
        logic signed [GRAD_W-1:0] grad_y;
        logic [IDX_W-1:0]         cell_x;
        logic [IDX_W-1:0]         cell_y;
    } t_item;

endpackage

[src/gn2d_ram.sv]
`timescale 1ns / 1ps
// gn2d_ram: generic RAM, one write port and two registered read ports.
// No dependencies.
module gn2d_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr0,
    input  logic [$clog2(DEPTH)-1:0] i_raddr1,
    output logic [WIDTH-1:0]         o_rdata0,
    output logic [WIDTH-1:0]         o_rdata1
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata0;
    logic [WIDTH-1:0] r_rdata1;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata0 <= r_mem[i_raddr0];
            r_rdata1 <= r_mem[i_raddr1];
        end
    end

    assign o_rdata0 = r_rdata0;
    assign o_rdata1 = r_rdata1;

endmodule

[src/gn2d_front.sv]
`timescale 1ns / 1ps
// gn2d_front: decodes incoming transactions, drops unused commands and
// splits the sample point into cell and fraction. Depends on gn2d_pkg.
module gn2d_front #(
    parameter int FRAC_BITS = gn2d_pkg::FRAC_BITS_DEF
) (
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [1:0]                            i_cmd,
    input  logic [7:0]                            i_table_index,
    input  logic [gn2d_pkg::PERM_W-1:0]           i_perm_value,
    input  logic signed [gn2d_pkg::GRAD_W-1:0]    i_grad_x,
    input  logic signed [gn2d_pkg::GRAD_W-1:0]    i_grad_y,
    input  logic signed [gn2d_pkg::COORD_W-1:0]   i_x_coord,
    input  logic signed [gn2d_pkg::COORD_W-1:0]   i_y_coord,
    input  logic                                  i_full,
    output logic                                  o_push,
    output gn2d_pkg::t_item                       o_item,
    output logic [FRAC_BITS-1:0]                  o_frac_x,
    output logic [FRAC_BITS-1:0]                  o_frac_y
);

    localparam int IW    = gn2d_pkg::IDX_W;
    localparam int EXT_W = gn2d_pkg::COORD_W + IW;

    gn2d_pkg::t_cmd    kind;
    logic [EXT_W-1:0]  x_ext;
    logic [EXT_W-1:0]  y_ext;

    always_comb begin
        kind  = gn2d_pkg::t_cmd'(i_cmd);
        x_ext = {{IW{i_x_coord[gn2d_pkg::COORD_W-1]}}, i_x_coord};
        y_ext = {{IW{i_y_coord[gn2d_pkg::COORD_W-1]}}, i_y_coord};
        o_item.kind       = kind;
        o_item.tbl_index  = IW'(i_table_index);
        o_item.perm_value = i_perm_value;
        o_item.grad_x     = i_grad_x;
        o_item.grad_y     = i_grad_y;
        // floor of the coordinate, modulo table size
        o_item.cell_x     = x_ext[FRAC_BITS +: IW];
        o_item.cell_y     = y_ext[FRAC_BITS +: IW];
        o_frac_x          = i_x_coord[FRAC_BITS-1:0];
        o_frac_y          = i_y_coord[FRAC_BITS-1:0];
    end

    assign o_in_ready = !i_full;
    assign o_push     = i_in_valid && !i_full && (kind != gn2d_pkg::CMD_NONE);

endmodule

[src/gn2d_queue.sv]
`timescale 1ns / 1ps
// gn2d_queue: short FIFO between front and back.
// Depends on gn2d_pkg and gradient_noise_2d_top_defines.svh.
`include "gradient_noise_2d_top_defines.svh"
module gn2d_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = gn2d_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty,
    output logic             o_full
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_W'(DEPTH));

    `GN2D_ASSERT(a_no_push_full, o_full |-> !i_push, "push into full queue")
    `GN2D_ASSERT(a_no_pop_empty, o_empty |-> !i_pop, "pop from empty queue")
    `GN2D_ASSERT_NEXT(a_count_track, i_rst_n, r_count == $past(r_count) + CNT_W'($past(i_push)) - CNT_W'($past(i_pop)), "queue count mismatch")

endmodule

[src/gn2d_back.sv]
`timescale 1ns / 1ps
// gn2d_back: table lookups, dot products, fade and blend pipeline with
// the result register. Depends on gn2d_pkg and gn2d_ram.
module gn2d_back #(
    parameter int FRAC_BITS = gn2d_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_head_valid,
    input  gn2d_pkg::t_item                     i_item,
    input  logic [FRAC_BITS-1:0]                i_frac_x,
    input  logic [FRAC_BITS-1:0]                i_frac_y,
    output logic                                o_pop,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [gn2d_pkg::NOISE_W-1:0] o_noise_value
);

    localparam int IW    = gn2d_pkg::IDX_W;
    localparam int PW    = gn2d_pkg::PERM_W;
    localparam int GW    = gn2d_pkg::GRAD_W;
    localparam int NW    = gn2d_pkg::NOISE_W;
    localparam int T_W   = gn2d_pkg::FADE_T_W;
    localparam int K_W   = gn2d_pkg::FADE_W;
    localparam int TT_W  = 2 * T_W;
    localparam int AM_W  = T_W + K_W;
    localparam int W_W   = T_W + 1;
    localparam int OFS_W = FRAC_BITS + 1;
    localparam int P_W   = GW + OFS_W;
    localparam int D_W   = FRAC_BITS + 18;
    localparam int E_W   = D_W + 1;
    localparam int M_W   = E_W + W_W + 1;
    localparam int R_W   = D_W + 1;
    localparam int FIRST_EV = 3;
    localparam int LAST_EV  = 10;
    localparam logic signed [R_W-1:0] RND    = R_W'(64'd1 << (FRAC_BITS - 2));
    localparam logic signed [R_W-1:0] SAT_HI = R_W'((64'd1 << (NW - 1)) - 64'd1);
    localparam logic signed [R_W-1:0] SAT_LO = ~SAT_HI;

    function automatic logic signed [D_W-1:0] corner_dot(
        input logic [2*GW-1:0]          g,
        input logic signed [OFS_W-1:0]  vx,
        input logic signed [OFS_W-1:0]  vy
    );
        logic signed [P_W-1:0] px;
        logic signed [P_W-1:0] py;
        px = $signed(g[GW-1:0]) * vx;
        py = $signed(g[2*GW-1:GW]) * vy;
        return D_W'(px) + D_W'(py);
    endfunction

    logic adv;
    logic pop;

    // lookup stages
    logic [PW-1:0]          a_rd0, a_rd1;
    logic [PW-1:0]          b_rd0, b_rd1, c_rd0, c_rd1;
    logic [2*GW-1:0]        d_rd0, d_rd1, e_rd0, e_rd1;

    logic                   r_v1, r_v2;
    gn2d_pkg::t_cmd         r_k1, r_k2;
    logic [IW-1:0]          r_idx1, r_idx2;
    logic [PW-1:0]          r_perm1;
    logic signed [GW-1:0]   r_gx1, r_gy1, r_gx2, r_gy2;
    logic [IW-1:0]          r_cy1;
    logic [FRAC_BITS-1:0]   r_fx1, r_fy1, r_fx2, r_fy2, r_fx3, r_fy3;
    logic                   r_ev [FIRST_EV:LAST_EV];

    // fade
    logic [T_W-1:0]         t1 [2];
    logic [T_W-1:0]         r_t2 [2];
    logic [TT_W-1:0]        r_tt2 [2];
    logic [K_W-1:0]         k2 [2];
    logic [TT_W-1:0]        r_t3m3 [2];
    logic [AM_W-1:0]        r_am3 [2];
    logic [K_W-1:0]         c3 [2];
    logic [AM_W-1:0]        r_fm4 [2];

    // dot and blend
    logic signed [OFS_W-1:0] vx0, vx1, vy0, vy1;
    logic signed [D_W-1:0]  r_d00, r_d01, r_d10, r_d11;
    logic signed [E_W-1:0]  r_e05, r_e15, r_e28;
    logic signed [D_W-1:0]  r_b05, r_b15, r_b06, r_b16, r_b28, r_b29;
    logic [W_W-1:0]         r_wx5, r_wy5, r_wy6, r_wy7, r_wy8;
    logic signed [M_W-1:0]  r_m06, r_m16, r_m29;
    logic signed [M_W-1:0]  sh0, sh1, sh2;
    logic signed [D_W-1:0]  r_up7, r_lo7, r_v10;
    logic signed [R_W-1:0]  vr, vs;
    logic signed [NW-1:0]   sat;
    logic                   r_out_valid;
    logic signed [NW-1:0]   r_noise;

    assign adv = !r_out_valid || i_out_ready;
    assign pop = adv && i_head_valid;

    // first perm lookup: cell x and its neighbor
    gn2d_ram #(.WIDTH(PW), .DEPTH(gn2d_pkg::TABLE_SIZE)) u_perm_a (
        .i_clk    (i_clk),
        .i_we     (pop && (i_item.kind == gn2d_pkg::CMD_WPERM)),
        .i_waddr  (i_item.tbl_index),
        .i_wdata  (i_item.perm_value),
        .i_re     (adv),
        .i_raddr0 (i_item.cell_x),
        .i_raddr1 (i_item.cell_x + IW'(1)),
        .o_rdata0 (a_rd0),
        .o_rdata1 (a_rd1)
    );

    // second perm lookup, column x0 and column x0+1
    gn2d_ram #(.WIDTH(PW), .DEPTH(gn2d_pkg::TABLE_SIZE)) u_perm_b (
        .i_clk    (i_clk),
        .i_we     (adv && r_v1 && (r_k1 == gn2d_pkg::CMD_WPERM)),
        .i_waddr  (r_idx1),
        .i_wdata  (r_perm1),
        .i_re     (adv),
        .i_raddr0 (IW'(a_rd0) + r_cy1),
        .i_raddr1 (IW'(a_rd0) + r_cy1 + IW'(1)),
        .o_rdata0 (b_rd0),
        .o_rdata1 (b_rd1)
    );

    gn2d_ram #(.WIDTH(PW), .DEPTH(gn2d_pkg::TABLE_SIZE)) u_perm_c (
        .i_clk    (i_clk),
        .i_we     (adv && r_v1 && (r_k1 == gn2d_pkg::CMD_WPERM)),
        .i_waddr  (r_idx1),
        .i_wdata  (r_perm1),
        .i_re     (adv),
        .i_raddr0 (IW'(a_rd1) + r_cy1),
        .i_raddr1 (IW'(a_rd1) + r_cy1 + IW'(1)),
        .o_rdata0 (c_rd0),
        .o_rdata1 (c_rd1)
    );

    // gradients: row y0 and row y0+1
    gn2d_ram #(.WIDTH(2 * GW), .DEPTH(gn2d_pkg::TABLE_SIZE)) u_grad_d (
        .i_clk    (i_clk),
        .i_we     (adv && r_v2 && (r_k2 == gn2d_pkg::CMD_WGRAD)),
        .i_waddr  (r_idx2),
        .i_wdata  ({r_gy2, r_gx2}),
        .i_re     (adv),
        .i_raddr0 (IW'(b_rd0)),
        .i_raddr1 (IW'(c_rd0)),
        .o_rdata0 (d_rd0),
        .o_rdata1 (d_rd1)
    );

    gn2d_ram #(.WIDTH(2 * GW), .DEPTH(gn2d_pkg::TABLE_SIZE)) u_grad_e (
        .i_clk    (i_clk),
        .i_we     (adv && r_v2 && (r_k2 == gn2d_pkg::CMD_WGRAD)),
        .i_waddr  (r_idx2),
        .i_wdata  ({r_gy2, r_gx2}),
        .i_re     (adv),
        .i_raddr0 (IW'(b_rd1)),
        .i_raddr1 (IW'(c_rd1)),
        .o_rdata0 (e_rd0),
        .o_rdata1 (e_rd1)
    );

    if (FRAC_BITS >= T_W) begin : g_t_down
        assign t1[0] = r_fx1[FRAC_BITS-1 -: T_W];
        assign t1[1] = r_fy1[FRAC_BITS-1 -: T_W];
    end else begin : g_t_up
        assign t1[0] = {r_fx1, {(T_W - FRAC_BITS){1'b0}}};
        assign t1[1] = {r_fy1, {(T_W - FRAC_BITS){1'b0}}};
    end

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            k2[i] = gn2d_pkg::FADE_C15
                  - (K_W'({r_t2[i], 2'b00}) + K_W'({r_t2[i], 1'b0}));
            c3[i] = gn2d_pkg::FADE_C10 - r_am3[i][AM_W-1:T_W];
        end
        vx0 = $signed({1'b0, r_fx3});
        vx1 = $signed({1'b1, r_fx3});
        vy0 = $signed({1'b0, r_fy3});
        vy1 = $signed({1'b1, r_fy3});
        sh0 = r_m06 >>> T_W;
        sh1 = r_m16 >>> T_W;
        sh2 = r_m29 >>> T_W;
        vr  = R_W'(r_v10) + RND;
        vs  = vr >>> (FRAC_BITS - 1);
        if (vs > SAT_HI) begin
            sat = NW'(SAT_HI);
        end else if (vs < SAT_LO) begin
            sat = NW'(SAT_LO);
        end else begin
            sat = NW'(vs);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = FIRST_EV; i <= LAST_EV; i++) begin
                r_ev[i] <= 1'b0;
            end
        end else if (adv) begin
            r_v1          <= pop;
            r_v2          <= r_v1;
            r_ev[FIRST_EV] <= r_v2 && (r_k2 == gn2d_pkg::CMD_EVAL);
            for (int i = FIRST_EV + 1; i <= LAST_EV; i++) begin
                r_ev[i] <= r_ev[i-1];
            end
            r_out_valid   <= r_ev[LAST_EV];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_k1    <= i_item.kind;
            r_idx1  <= i_item.tbl_index;
            r_perm1 <= i_item.perm_value;
            r_gx1   <= i_item.grad_x;
            r_gy1   <= i_item.grad_y;
            r_cy1   <= i_item.cell_y;
            r_fx1   <= i_frac_x;
            r_fy1   <= i_frac_y;

            r_k2    <= r_k1;
            r_idx2  <= r_idx1;
            r_gx2   <= r_gx1;
            r_gy2   <= r_gy1;
            r_fx2   <= r_fx1;
            r_fy2   <= r_fy1;
            r_fx3   <= r_fx2;
            r_fy3   <= r_fy2;

            for (int i = 0; i < 2; i++) begin
                r_t2[i]   <= t1[i];
                r_tt2[i]  <= TT_W'(t1[i]) * TT_W'(t1[i]);
                r_t3m3[i] <= TT_W'(r_tt2[i][TT_W-1:T_W]) * TT_W'(r_t2[i]);
                r_am3[i]  <= AM_W'(r_t2[i]) * AM_W'(k2[i]);
                r_fm4[i]  <= AM_W'(r_t3m3[i][TT_W-1:T_W]) * AM_W'(c3[i]);
            end

            r_d00 <= corner_dot(d_rd0, vx0, vy0);
            r_d01 <= corner_dot(d_rd1, vx1, vy0);
            r_d10 <= corner_dot(e_rd0, vx0, vy1);
            r_d11 <= corner_dot(e_rd1, vx1, vy1);

            r_e05 <= E_W'(r_d01) - E_W'(r_d00);
            r_e15 <= E_W'(r_d11) - E_W'(r_d10);
            r_b05 <= r_d00;
            r_b15 <= r_d10;
            r_wx5 <= r_fm4[0][T_W +: W_W];
            r_wy5 <= r_fm4[1][T_W +: W_W];

            r_m06 <= r_e05 * $signed({1'b0, r_wx5});
            r_m16 <= r_e15 * $signed({1'b0, r_wx5});
            r_b06 <= r_b05;
            r_b16 <= r_b15;
            r_wy6 <= r_wy5;

            r_up7 <= r_b06 + D_W'(sh0);
            r_lo7 <= r_b16 + D_W'(sh1);
            r_wy7 <= r_wy6;

            r_e28 <= E_W'(r_lo7) - E_W'(r_up7);
            r_b28 <= r_up7;
            r_wy8 <= r_wy7;

            r_m29 <= r_e28 * $signed({1'b0, r_wy8});
            r_b29 <= r_b28;

            r_v10   <= r_b29 + D_W'(sh2);
            r_noise <= sat;
        end
    end

    assign o_pop         = pop;
    assign o_out_valid   = r_out_valid;
    assign o_noise_value = r_noise;

endmodule

[src/gradient_noise_2d_top.sv]
`timescale 1ns / 1ps
// gradient_noise_2d_top: 2D gradient noise, front decode, queue, back pipeline.
// Depends on gn2d_pkg, gn2d_front, gn2d_queue, gn2d_back.
//
//  channel | valid       | ready       | payload
//  --------+-------------+-------------+------------------------------------------
//  in      | i_in_valid  | o_in_ready  | i_cmd i_table_index i_perm_value i_grad_*
//          |             |             | i_x_coord i_y_coord
//  out     | o_out_valid | i_out_ready | o_noise_value
//
// One transaction per clock while the queue is not full. A noise result passes
// through the back pipeline (three RAM lookups, fade multiplies, blends).
// Table writes travel the same pipeline and give no result; cmd 3 is dropped.
// Reset clears control only; tables must be loaded before evaluation.
// A low i_out_ready while a result waits freezes the back pipeline; the
// QUEUE_DEPTH-entry queue then fills and o_in_ready drops.
module gradient_noise_2d_top #(
    parameter int FRAC_BITS   = gn2d_pkg::FRAC_BITS_DEF,
    parameter int QUEUE_DEPTH = gn2d_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [1:0]                           i_cmd,
    input  logic [7:0]                           i_table_index,
    input  logic [gn2d_pkg::PERM_W-1:0]          i_perm_value,
    input  logic signed [gn2d_pkg::GRAD_W-1:0]   i_grad_x,
    input  logic signed [gn2d_pkg::GRAD_W-1:0]   i_grad_y,
    input  logic signed [gn2d_pkg::COORD_W-1:0]  i_x_coord,
    input  logic signed [gn2d_pkg::COORD_W-1:0]  i_y_coord,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [gn2d_pkg::NOISE_W-1:0]  o_noise_value
);

    localparam int ITEM_W = $bits(gn2d_pkg::t_item);
    localparam int Q_W    = ITEM_W + 2 * FRAC_BITS;

    gn2d_pkg::t_item        push_item, pop_item;
    logic [FRAC_BITS-1:0]   push_fx, push_fy;
    logic                   push, pop, q_empty, q_full;
    logic [Q_W-1:0]         q_out;

    gn2d_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_cmd         (i_cmd),
        .i_table_index (i_table_index),
        .i_perm_value  (i_perm_value),
        .i_grad_x      (i_grad_x),
        .i_grad_y      (i_grad_y),
        .i_x_coord     (i_x_coord),
        .i_y_coord     (i_y_coord),
        .i_full        (q_full),
        .o_push        (push),
        .o_item        (push_item),
        .o_frac_x      (push_fx),
        .o_frac_y      (push_fy)
    );

    gn2d_queue #(.WIDTH(Q_W), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({push_fx, push_fy, push_item}),
        .i_pop   (pop),
        .o_data  (q_out),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    assign pop_item = gn2d_pkg::t_item'(q_out[ITEM_W-1:0]);

    gn2d_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head_valid  (!q_empty),
        .i_item        (pop_item),
        .i_frac_x      (q_out[Q_W-1 -: FRAC_BITS]),
        .i_frac_y      (q_out[ITEM_W +: FRAC_BITS]),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_noise_value (o_noise_value)
    );

endmodule

[dv/gn2d_checker.sv]
`timescale 1ns / 1ps
// gn2d_checker: watches both channels of gradient_noise_2d_top, predicts each
// noise result from its own copy of the tables, and counts mismatches.
// Depends on gn2d_pkg.
module gn2d_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [1:0]         i_cmd,
    input  logic [7:0]         i_table_index,
    input  logic [7:0]         i_perm_value,
    input  logic signed [15:0] i_grad_x,
    input  logic signed [15:0] i_grad_y,
    input  logic signed [31:0] i_x_coord,
    input  logic signed [31:0] i_y_coord,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic signed [15:0] i_noise_value,
    output int                 o_errors,
    output int                 o_pending
);

    logic [7:0]         perm_mem [gn2d_pkg::TABLE_SIZE];
    logic signed [15:0] gx_mem [gn2d_pkg::TABLE_SIZE];
    logic signed [15:0] gy_mem [gn2d_pkg::TABLE_SIZE];
    logic signed [15:0] noise_q [$];

    function automatic longint corner_dot(logic [7:0] cx, logic [7:0] cy,
                                          longint vx, longint vy);
        logic [7:0] h;
        h = perm_mem[cx];
        h = perm_mem[8'(h + cy)];
        return longint'(gx_mem[h]) * vx + longint'(gy_mem[h]) * vy;
    endfunction

    function automatic longint fade_weight(logic [15:0] f);
        longint t, t3, a;
        t  = longint'(f);
        t3 = (((t * t) >> 16) * t) >> 16;
        a  = (t * (15 * 65536 - 6 * t)) >> 16;
        return (t3 * (10 * 65536 - a)) >> 16;
    endfunction

    function automatic longint blend(longint a, longint b, longint w);
        return a + (((b - a) * w) >>> 16);
    endfunction

    function automatic logic signed [15:0] noise_at(logic signed [31:0] x,
                                                     logic signed [31:0] y);
        logic signed [31:0] xc, yc;
        logic [7:0] cx, cy;
        longint fx, fy, one, d00, d01, d10, d11, wx, wy, v;
        xc  = x >>> 16;
        yc  = y >>> 16;
        cx  = xc[7:0];
        cy  = yc[7:0];
        fx  = longint'(x[15:0]);
        fy  = longint'(y[15:0]);
        one = 65536;
        d00 = corner_dot(cx, cy, fx, fy);
        d01 = corner_dot(8'(cx + 1), cy, fx - one, fy);
        d10 = corner_dot(cx, 8'(cy + 1), fx, fy - one);
        d11 = corner_dot(8'(cx + 1), 8'(cy + 1), fx - one, fy - one);
        wx  = fade_weight(x[15:0]);
        wy  = fade_weight(y[15:0]);
        v   = blend(blend(d00, d01, wx), blend(d10, d11, wx), wy);
        v   = (v + (longint'(1) << 14)) >>> 15;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return 16'(v);
    endfunction

    always @(posedge i_clk) begin
        logic signed [15:0] want;
        if (!i_rst_n) begin
            noise_q.delete();
            o_errors  = 0;
            o_pending = 0;
        end else begin
            if (i_in_valid && i_in_ready) begin
                case (gn2d_pkg::t_cmd'(i_cmd))
                    gn2d_pkg::CMD_EVAL:
                        noise_q.push_back(noise_at(i_x_coord, i_y_coord));
                    gn2d_pkg::CMD_WPERM: perm_mem[i_table_index] = i_perm_value;
                    gn2d_pkg::CMD_WGRAD: begin
                        gx_mem[i_table_index] = i_grad_x;
                        gy_mem[i_table_index] = i_grad_y;
                    end
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (noise_q.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10)
                        $display("%0t: unexpected noise result %0d", $realtime, i_noise_value);
                end else begin
                    want = noise_q.pop_front();
                    if (want !== i_noise_value) begin
                        o_errors++;
                        if (o_errors <= 10)
                            $display("%0t: noise_value expected %0d actual %0d",
                                     $realtime, want, i_noise_value);
                    end
                end
            end
            o_pending = noise_q.size();
        end
    end
endmodule

[dv/gradient_noise_2d_top_tb.sv]
`timescale 1ns / 1ps
// gradient_noise_2d_top_tb: loads the tables, then drives directed and random
// transactions into gradient_noise_2d_top with random stalls.
// Depends on gn2d_pkg, gn2d_checker, gradient_noise_2d_top.
module gradient_noise_2d_top_tb;

    localparam int CYCLE_LIMIT = 400000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [1:0]         cmd = gn2d_pkg::CMD_NONE;
    logic [7:0]         table_index = '0;
    logic [7:0]         perm_value = '0;
    logic signed [15:0] grad_x = '0;
    logic signed [15:0] grad_y = '0;
    logic signed [31:0] x_coord = '0;
    logic signed [31:0] y_coord = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [15:0] noise_value;
    int                 errors, pending;
    int                 cyc = 0;

    gradient_noise_2d_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_cmd(cmd), .i_table_index(table_index), .i_perm_value(perm_value),
        .i_grad_x(grad_x), .i_grad_y(grad_y),
        .i_x_coord(x_coord), .i_y_coord(y_coord),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_noise_value(noise_value)
    );

    gn2d_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready),
        .i_cmd(cmd), .i_table_index(table_index), .i_perm_value(perm_value),
        .i_grad_x(grad_x), .i_grad_y(grad_y),
        .i_x_coord(x_coord), .i_y_coord(y_coord),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_noise_value(noise_value),
        .o_errors(errors), .o_pending(pending)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // receiver: random stalls, with at least one long hold-off to back the queue up
    initial begin
        int run, stall, holds;
        holds = 0;
        wait (i_rst_n);
        forever begin
            run = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
            @(posedge i_clk) out_ready <= 1'b1;
            repeat (run) @(posedge i_clk);
            if (holds == 0 && cyc > 2500) begin
                stall = $urandom_range(150, 300);
                holds++;
            end else if ($urandom_range(0, 60) == 0) begin
                stall = $urandom_range(150, 300);
            end else if ($urandom_range(0, 9) == 0) begin
                stall = $urandom_range(10, 40);
            end else begin
                stall = $urandom_range(1, 4);
            end
            out_ready <= 1'b0;
            repeat (stall) @(posedge i_clk);
        end
    end

    task automatic send(gn2d_pkg::t_cmd c, logic [7:0] idx, logic [7:0] pv,
                        logic [15:0] gx, logic [15:0] gy, logic [31:0] x,
                        logic [31:0] y);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) :
              ($urandom_range(0, 1) ? 0 : $urandom_range(1, 3));
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid    <= 1'b1;
        cmd         <= c;
        table_index <= idx;
        perm_value  <= pv;
        grad_x      <= gx;
        grad_y      <= gy;
        x_coord     <= x;
        y_coord     <= y;
        do @(negedge i_clk); while (!in_ready);
        @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_grad();
        if ($urandom_range(0, 7) == 0) return 16'($urandom());
        return 16'($urandom_range(0, 32768) - 16384);
    endfunction

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return {16'($urandom_range(0, 7)), 16'($urandom())};
            2: return {16'(-$urandom_range(1, 8)), 16'($urandom())};
            default: return {16'($urandom()), 16'($urandom_range(0, 1) ? 16'hffff : 16'h0000)};
        endcase
    endfunction

    initial begin
        logic [31:0] edge_pts [10];
        int r;
        edge_pts = '{32'h0000_0000, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                     32'h0001_0000, 32'hffff_0000, 32'h0000_8000, 32'h0000_ffff,
                     32'h00ff_7fff, 32'hff00_0001};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < gn2d_pkg::TABLE_SIZE; i++)
            send(gn2d_pkg::CMD_WPERM, 8'(i), 8'($urandom()), 16'($urandom()),
                 16'($urandom()), $urandom(), $urandom());
        for (int i = 0; i < gn2d_pkg::TABLE_SIZE; i++)
            send(gn2d_pkg::CMD_WGRAD, 8'(i), 8'($urandom()), pick_grad(), pick_grad(),
                 $urandom(), $urandom());

        // directed: coordinate extremes, gradient and perm extremes, unused command
        for (int i = 0; i < 10; i++)
            send(gn2d_pkg::CMD_EVAL, 8'($urandom()), 8'($urandom()), 16'($urandom()),
                 16'($urandom()), edge_pts[i], edge_pts[9 - i]);
        send(gn2d_pkg::CMD_WGRAD, 8'd0, 8'd0, 16'h8000, 16'h7fff, 32'd0, 32'd0);
        send(gn2d_pkg::CMD_WGRAD, 8'd255, 8'd255, 16'h4000, 16'hc000, 32'd0, 32'd0);
        send(gn2d_pkg::CMD_WGRAD, 8'd1, 8'd0, 16'h7fff, 16'h7fff, 32'd0, 32'd0);
        send(gn2d_pkg::CMD_WPERM, 8'd255, 8'd0, 16'd0, 16'd0, 32'd0, 32'd0);
        send(gn2d_pkg::CMD_WPERM, 8'd0, 8'd255, 16'd0, 16'd0, 32'd0, 32'd0);
        send(gn2d_pkg::CMD_NONE, 8'hff, 8'hff, 16'hffff, 16'hffff, 32'hffff_ffff,
             32'hffff_ffff);
        for (int i = 0; i < 6; i++)
            send(gn2d_pkg::CMD_EVAL, 8'd0, 8'd0, 16'd0, 16'd0,
                 edge_pts[$urandom_range(0, 9)], edge_pts[$urandom_range(0, 9)]);

        for (int n = 0; n < 400; n++) begin
            r = $urandom_range(0, 99);
            send(gn2d_pkg::t_cmd'(r < 70 ? gn2d_pkg::CMD_EVAL :
                                  r < 82 ? gn2d_pkg::CMD_WPERM :
                                  r < 94 ? gn2d_pkg::CMD_WGRAD : gn2d_pkg::CMD_NONE),
                 8'($urandom()), 8'($urandom()), pick_grad(), pick_grad(),
                 pick_coord(), pick_coord());
        end
        in_valid <= 1'b0;
        repeat (2) @(posedge i_clk);

        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (errors == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
